[sv/i2da_pkg.sv]
// shared constants for the signed integer to decimal text converter
package i2da_pkg;

	localparam int VALUE_W    = 32;
	localparam int CODE_W     = 6;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int STEP_W     = $clog2(VALUE_W);
	localparam int DIG_W      = $clog2(NUM_DIGITS);

	localparam logic [CODE_W-1:0] CHAR_ZERO  = CODE_W'(48);
	localparam logic [CODE_W-1:0] CHAR_MINUS = CODE_W'(45);

	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;

endpackage

[sv/i2da_if.sv]
// valid/ready channels for integer words in and character words out
interface i2da_value_if;
	import i2da_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface i2da_char_if;
	import i2da_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] char_code;
	logic              last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

[sv/int_to_decimal_ascii_core.sv]
// signed 32-bit integer to decimal ascii text converter, top level
//
// value_ch carries one signed 32-bit integer per word. text_ch returns its
// decimal text, one ascii character per word, most significant first: a
// leading '-' for negative values, '0' alone for zero, and last_char set on
// the final character of each number (no terminator word).
// Conversion uses a single shift-and-add-3 unit on a ten digit bcd
// register, one bit per cycle through the whole magnitude, then a step
// to locate the leading digit, then one character per cycle while
// text_ch is ready. Each number gives n = 1 to 11 characters; the first
// is registered in ST_EMIT, after the ST_CONV and ST_FIND states.
// value_ch.ready is high only while the block is idle; the final character
// sits in an output register, so the next integer may be taken while it
// still waits.
// If text_ch stalls, the current character holds and conversion of the
// next character waits. arst_n clears the sequencer and the output valid.
module int_to_decimal_ascii_core (
	input  logic        clk,
	input  logic        arst_n,
	i2da_value_if.sink  value_ch,
	i2da_char_if.source text_ch
);
	import i2da_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] mag_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [STEP_W-1:0]  step_q;
	logic               neg_q;
	logic               sign_pend_q;
	logic [DIG_W-1:0]   dig_q;
	logic               out_valid_q;
	logic [CODE_W-1:0]  out_code_q;
	logic               out_last_q;

	logic [BCD_W-1:0]   bcd_adj;
	logic [DIG_W-1:0]   lead_dig;
	logic [3:0]         cur_digit;
	logic               out_free;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= BCD_ADJ_MIN) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + BCD_ADJ;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// highest nonzero digit, or the lowest one for zero
	always_comb begin
		lead_dig = '0;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				lead_dig = DIG_W'(i);
			end
		end
	end

	assign cur_digit = bcd_q[4*dig_q +: 4];
	assign out_free  = !out_valid_q || text_ch.ready;

	assign value_ch.ready    = (state_q == ST_IDLE);
	assign text_ch.valid     = out_valid_q;
	assign text_ch.char_code = out_code_q;
	assign text_ch.last_char = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			sign_pend_q <= 1'b0;
		end else begin
			if (out_valid_q && text_ch.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (value_ch.valid) begin
						neg_q   <= value_ch.value[VALUE_W-1];
						mag_q   <= value_ch.value[VALUE_W-1] ?
						           (~value_ch.value + VALUE_W'(1)) : value_ch.value;
						bcd_q   <= '0;
						step_q  <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q  <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
					mag_q  <= {mag_q[VALUE_W-2:0], 1'b0};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(VALUE_W - 1)) begin
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					dig_q       <= lead_dig;
					sign_pend_q <= neg_q;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (sign_pend_q) begin
							out_code_q  <= CHAR_MINUS;
							out_last_q  <= 1'b0;
							sign_pend_q <= 1'b0;
						end else begin
							out_code_q <= CHAR_ZERO + CODE_W'(cur_digit);
							out_last_q <= (dig_q == '0);
							if (dig_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								dig_q <= dig_q - DIG_W'(1);
							end
						end
					end else begin
						out_valid_q <= out_valid_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
